FILE: design/cwed_pkg.sv
// Package for the closest-word edit distance block: sizes, field widths and
// the link record passed from one distance cell to the next.
// Depends on nothing; used by cwed_cell and closest_word_edit_distance_top.
`timescale 1ns / 1ps

package cwed_pkg;

  localparam int MAX_LEN   = 32;
  localparam int MAX_WORDS = 1024;
  localparam int LEN_W     = $clog2(MAX_LEN + 2);
  localparam int ADDR_W    = $clog2(MAX_LEN);
  localparam int IDX_W     = $clog2(MAX_WORDS);
  localparam int CHAR_W    = 8;

  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] code;
    logic [LEN_W-1:0]  left;
    logic [LEN_W-1:0]  diag;
  } cwed_link_t;

endpackage

FILE: design/closest_word_edit_distance_top.sv
// Top level of the closest-word edit distance block: request handling, query
// and list bookkeeping, the chain of distance cells and the result register.
// Depends on cwed_pkg and cwed_cell.
`timescale 1ns / 1ps

// Usage: the input channel carries one byte request per cycle. Query bytes
// (cmd 0) are stored in the cells; candidate bytes (cmd 1) enter a chain of
// 32 cells and move one cell per cycle, so bytes of one word are taken back
// to back at one per cycle. On a candidate's last byte the block stops taking
// requests until the chain has drained, then loads one result into the output
// register and takes requests again. A query byte that arrives while candidate
// bytes are still in the chain waits for the same drain. The result register
// holds its request until out_ready; while it waits the block keeps taking
// bytes, and only the next candidate end waits for the register to free. The
// configuration channel is always ready and writes the distance limit. After
// the synchronous active-low reset the query is empty, the list is cleared
// and the limit is 2.
module closest_word_edit_distance_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [cwed_pkg::LEN_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_cmd,
  input  logic [cwed_pkg::CHAR_W-1:0] in_char_code,
  input  logic                       in_has_char,
  input  logic                       in_last_char,
  input  logic                       in_last_word,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [cwed_pkg::IDX_W-1:0] out_word_index,
  output logic [cwed_pkg::LEN_W-1:0] out_word_distance,
  output logic                       out_word_eligible,
  output logic                       out_list_done,
  output logic                       out_best_found,
  output logic [cwed_pkg::IDX_W-1:0] out_best_index,
  output logic [cwed_pkg::LEN_W-1:0] out_best_distance,
  output logic                       out_overflow
);

  typedef enum logic {S_RUN, S_DRAIN} state_t;

  localparam logic [cwed_pkg::LEN_W-1:0] LenMax = cwed_pkg::LEN_W'(cwed_pkg::MAX_LEN);
  localparam logic [cwed_pkg::LEN_W-1:0] One    = cwed_pkg::LEN_W'(1);

  state_t                      state_r, state_nxt;
  logic [cwed_pkg::LEN_W-1:0]  limit_r, limit_nxt;
  logic [cwed_pkg::LEN_W-1:0]  qlen_r, qlen_nxt;
  logic                        qdone_r, qdone_nxt;
  logic                        qovf_r, qovf_nxt;
  logic [cwed_pkg::LEN_W-1:0]  clen_r, clen_nxt;
  logic                        covf_r, covf_nxt;
  logic [cwed_pkg::IDX_W-1:0]  count_r, count_nxt;
  logic                        bvalid_r, bvalid_nxt;
  logic [cwed_pkg::IDX_W-1:0]  bidx_r, bidx_nxt;
  logic [cwed_pkg::LEN_W-1:0]  bdist_r, bdist_nxt;
  logic                        lastw_r, lastw_nxt;
  cwed_pkg::cwed_link_t        head_r, head_nxt;

  logic                        ovalid_r, ovalid_nxt;
  logic [cwed_pkg::IDX_W-1:0]  oidx_r, oidx_nxt;
  logic [cwed_pkg::LEN_W-1:0]  odist_r, odist_nxt;
  logic                        oelig_r, oelig_nxt;
  logic                        odone_r, odone_nxt;
  logic                        obfound_r, obfound_nxt;
  logic [cwed_pkg::IDX_W-1:0]  obidx_r, obidx_nxt;
  logic [cwed_pkg::LEN_W-1:0]  obdist_r, obdist_nxt;
  logic                        oovf_r, oovf_nxt;

  cwed_pkg::cwed_link_t        links [cwed_pkg::MAX_LEN+1];
  logic [cwed_pkg::LEN_W-1:0]  cell_d [cwed_pkg::MAX_LEN];
  logic [cwed_pkg::MAX_LEN:0]  link_busy;
  logic                        pipe_empty;
  logic                        init_row;
  logic                        q_wr;
  logic [cwed_pkg::ADDR_W-1:0] q_addr;
  logic                        in_acc;
  logic [cwed_pkg::LEN_W-1:0]  qlen_eff, clen_eff;
  logic [cwed_pkg::LEN_W-1:0]  m_dec;
  logic [cwed_pkg::LEN_W-1:0]  res_d;
  logic [cwed_pkg::LEN_W-1:0]  res_gap;
  logic                        res_ovf;
  logic                        res_elig;
  logic                        res_load;

  assign links[0] = head_r;

  for (genvar j = 0; j < cwed_pkg::MAX_LEN; j++) begin : g_cell
    cwed_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .init     (init_row),
      .cell_pos (cwed_pkg::LEN_W'(j + 1)),
      .q_we     (q_wr && (q_addr == cwed_pkg::ADDR_W'(j))),
      .q_data   (in_char_code),
      .link_i   (links[j]),
      .link_o   (links[j+1]),
      .d_o      (cell_d[j])
    );
  end

  always_comb begin
    for (int k = 0; k <= cwed_pkg::MAX_LEN; k++) begin
      link_busy[k] = links[k].valid;
    end
  end

  assign pipe_empty = ~|link_busy;
  assign cfg_ready  = 1'b1;
  assign in_ready   = (state_r == S_RUN) && (in_cmd || pipe_empty);
  assign in_acc     = in_valid && in_ready;

  always_comb begin
    m_dec   = qlen_r - One;
    res_d   = (qlen_r == '0) ? clen_r : cell_d[m_dec[cwed_pkg::ADDR_W-1:0]];
    res_gap = (qlen_r > clen_r) ? (qlen_r - clen_r) : (clen_r - qlen_r);
    res_ovf = qovf_r || covf_r;
    res_elig = !res_ovf && (res_gap <= limit_r) && (res_d <= limit_r);
    res_load = (state_r == S_DRAIN) && pipe_empty && (!ovalid_r || out_ready);
  end

  always_comb begin
    state_nxt   = state_r;
    limit_nxt   = limit_r;
    qlen_nxt    = qlen_r;
    qdone_nxt   = qdone_r;
    qovf_nxt    = qovf_r;
    clen_nxt    = clen_r;
    covf_nxt    = covf_r;
    count_nxt   = count_r;
    bvalid_nxt  = bvalid_r;
    bidx_nxt    = bidx_r;
    bdist_nxt   = bdist_r;
    lastw_nxt   = lastw_r;
    head_nxt    = head_r;
    head_nxt.valid = 1'b0;
    ovalid_nxt  = ovalid_r && !out_ready;
    oidx_nxt    = oidx_r;
    odist_nxt   = odist_r;
    oelig_nxt   = oelig_r;
    odone_nxt   = odone_r;
    obfound_nxt = obfound_r;
    obidx_nxt   = obidx_r;
    obdist_nxt  = obdist_r;
    oovf_nxt    = oovf_r;
    init_row    = 1'b0;
    q_wr        = 1'b0;
    qlen_eff    = qdone_r ? '0 : qlen_r;
    clen_eff    = qdone_r ? clen_r : '0;
    q_addr      = qlen_eff[cwed_pkg::ADDR_W-1:0];

    if (cfg_valid) begin
      limit_nxt = cfg_data;
    end

    if (in_acc) begin
      if (!in_cmd) begin
        if (qdone_r) begin
          qovf_nxt   = 1'b0;
          qdone_nxt  = 1'b0;
          init_row   = 1'b1;
          clen_nxt   = '0;
          covf_nxt   = 1'b0;
          count_nxt  = '0;
          bvalid_nxt = 1'b0;
          bidx_nxt   = '0;
          bdist_nxt  = '0;
        end
        qlen_nxt = qlen_eff;
        if (in_has_char) begin
          if (qlen_eff < LenMax) begin
            q_wr     = 1'b1;
            qlen_nxt = qlen_eff + One;
          end else begin
            qovf_nxt = 1'b1;
          end
        end
        if (in_last_char) begin
          qdone_nxt = 1'b1;
          init_row  = 1'b1;
          clen_nxt  = '0;
          covf_nxt  = 1'b0;
        end
      end else begin
        if (!qdone_r) begin
          qdone_nxt = 1'b1;
          init_row  = 1'b1;
          clen_nxt  = '0;
          covf_nxt  = 1'b0;
        end
        if (in_has_char) begin
          if (clen_eff < LenMax) begin
            head_nxt.valid = 1'b1;
            head_nxt.code  = in_char_code;
            head_nxt.left  = clen_eff + One;
            head_nxt.diag  = clen_eff;
            clen_nxt       = clen_eff + One;
          end else begin
            covf_nxt = 1'b1;
          end
        end
        if (in_last_char) begin
          state_nxt = S_DRAIN;
          lastw_nxt = in_last_word;
        end
      end
    end

    if (res_load) begin
      ovalid_nxt = 1'b1;
      oidx_nxt   = count_r;
      odist_nxt  = res_d;
      oelig_nxt  = res_elig;
      odone_nxt  = lastw_r;
      oovf_nxt   = res_ovf;
      if (res_elig && (!bvalid_r || (res_d < bdist_r))) begin
        obfound_nxt = 1'b1;
        obidx_nxt   = count_r;
        obdist_nxt  = res_d;
      end else begin
        obfound_nxt = bvalid_r;
        obidx_nxt   = bidx_r;
        obdist_nxt  = bdist_r;
      end
      bvalid_nxt = obfound_nxt;
      bidx_nxt   = obidx_nxt;
      bdist_nxt  = obdist_nxt;
      count_nxt  = count_r + cwed_pkg::IDX_W'(1);
      init_row   = 1'b1;
      clen_nxt   = '0;
      covf_nxt   = 1'b0;
      state_nxt  = S_RUN;
      if (lastw_r) begin
        count_nxt  = '0;
        bvalid_nxt = 1'b0;
        bidx_nxt   = '0;
        bdist_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    head_r.code <= head_nxt.code;
    head_r.left <= head_nxt.left;
    head_r.diag <= head_nxt.diag;
    lastw_r     <= lastw_nxt;
    oidx_r      <= oidx_nxt;
    odist_r     <= odist_nxt;
    oelig_r     <= oelig_nxt;
    odone_r     <= odone_nxt;
    obfound_r   <= obfound_nxt;
    obidx_r     <= obidx_nxt;
    obdist_r    <= obdist_nxt;
    oovf_r      <= oovf_nxt;
    if (!rst_n) begin
      state_r      <= S_RUN;
      limit_r      <= cwed_pkg::LEN_W'(2);
      qlen_r       <= '0;
      qdone_r      <= 1'b0;
      qovf_r       <= 1'b0;
      clen_r       <= '0;
      covf_r       <= 1'b0;
      count_r      <= '0;
      bvalid_r     <= 1'b0;
      bidx_r       <= '0;
      bdist_r      <= '0;
      head_r.valid <= 1'b0;
      ovalid_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      limit_r      <= limit_nxt;
      qlen_r       <= qlen_nxt;
      qdone_r      <= qdone_nxt;
      qovf_r       <= qovf_nxt;
      clen_r       <= clen_nxt;
      covf_r       <= covf_nxt;
      count_r      <= count_nxt;
      bvalid_r     <= bvalid_nxt;
      bidx_r       <= bidx_nxt;
      bdist_r      <= bdist_nxt;
      head_r.valid <= head_nxt.valid;
      ovalid_r     <= ovalid_nxt;
    end
  end

  assign out_valid         = ovalid_r;
  assign out_word_index    = oidx_r;
  assign out_word_distance = odist_r;
  assign out_word_eligible = oelig_r;
  assign out_list_done     = odone_r;
  assign out_best_found    = obfound_r;
  assign out_best_index    = obidx_r;
  assign out_best_distance = obdist_r;
  assign out_overflow      = oovf_r;

endmodule

FILE: design/cwed_cell.sv
// One cell of the distance row: holds one query byte and one row value, and
// updates that value when a candidate byte passes, handing it to the next cell.
// Depends on cwed_pkg.
`timescale 1ns / 1ps

module cwed_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       init,
  input  logic [cwed_pkg::LEN_W-1:0] cell_pos,
  input  logic                       q_we,
  input  logic [cwed_pkg::CHAR_W-1:0] q_data,
  input  cwed_pkg::cwed_link_t       link_i,
  output cwed_pkg::cwed_link_t       link_o,
  output logic [cwed_pkg::LEN_W-1:0] d_o
);

  logic [cwed_pkg::CHAR_W-1:0] q_r;
  logic [cwed_pkg::LEN_W-1:0]  d_r;
  logic [cwed_pkg::LEN_W-1:0]  d_nxt;
  logic [cwed_pkg::LEN_W-1:0]  up_cost;
  logic [cwed_pkg::LEN_W-1:0]  left_cost;
  logic [cwed_pkg::LEN_W-1:0]  diag_cost;
  cwed_pkg::cwed_link_t        link_r;

  always_comb begin
    up_cost   = d_r + cwed_pkg::LEN_W'(1);
    left_cost = link_i.left + cwed_pkg::LEN_W'(1);
    diag_cost = link_i.diag + ((q_r != link_i.code) ? cwed_pkg::LEN_W'(1)
                                                     : cwed_pkg::LEN_W'(0));
    d_nxt = up_cost;
    if (left_cost < d_nxt) begin
      d_nxt = left_cost;
    end
    if (diag_cost < d_nxt) begin
      d_nxt = diag_cost;
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_r <= q_data;
    end
    link_r.code <= link_i.code;
    link_r.left <= d_nxt;
    link_r.diag <= d_r;
    if (!rst_n) begin
      d_r          <= cell_pos;
      link_r.valid <= 1'b0;
    end else begin
      link_r.valid <= link_i.valid;
      if (init) begin
        d_r <= cell_pos;
      end else if (link_i.valid) begin
        d_r <= d_nxt;
      end
    end
  end

  assign link_o = link_r;
  assign d_o    = d_r;

endmodule
